// ----- rtl/boundary_tag_heap_allocator_defines.svh -----
// Assertion macros shared by the allocator RTL.
`ifndef BOUNDARY_TAG_HEAP_ALLOCATOR_DEFINES_SVH
`define BOUNDARY_TAG_HEAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define BTA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define BTA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/bta_pkg.sv -----
// Types, constants and helper functions of the heap allocator.
package bta_pkg;

   localparam int ADDR_W = 36;

   localparam logic [1:0] MODE_INIT   = 2'd0;
   localparam logic [1:0] MODE_ALLOC  = 2'd1;
   localparam logic [1:0] MODE_FREE   = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic [31:0] SIZE_MASK    = 32'hFFFF_FFF8;
   localparam logic [31:0] HDR_PROLOGUE = 32'h0000_0009;
   localparam logic [31:0] HDR_EPILOGUE = 32'h0000_0001;
   localparam logic [31:0] HDR_EPI_INIT = 32'h0000_0003;
   localparam logic [15:0] CHUNK_RESET  = 16'h1000;

   typedef enum logic [4:0] {
      S_IDLE, S_INIT0, S_INIT1, S_INIT2, S_INIT3,
      S_GROW, S_GROW_H, S_GROW_W1, S_GROW_W2,
      S_MRG, S_MRG_H, S_MRG_N, S_MRG_F, S_MRG_P, S_MW2, S_MRET,
      S_SR1, S_SR2,
      S_PL, S_PL_H, S_PL_S1, S_PL_S2, S_PL_R, S_PL_N,
      S_FR_H, S_FR_W, S_FR_R, S_FR_N,
      S_DONE
   } state_type;

   // Chunk size rounded up to eight bytes, never zero.
   function automatic logic [16:0] chunk_eff(input logic [15:0] c);
      logic [16:0] r;
      r = (17'(c) + 17'd7) & 17'h1FFF8;
      return (r == 17'd0) ? 17'd8 : r;
   endfunction

   // Block size for a request: header plus payload, rounded to eight bytes.
   function automatic logic [16:0] alloc_size(input logic [15:0] req);
      return (req <= 16'd4) ? 17'd8 : ((17'(req) + 17'd11) & 17'h1FFF8);
   endfunction

endpackage

// ----- rtl/bta_req_if.sv -----
// Request channel interface of the heap allocator.
interface bta_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [15:0] req_bytes;
   logic [14:0] block_addr;

   modport source (output valid, mode, req_bytes, block_addr, input ready);
   modport sink (input valid, mode, req_bytes, block_addr, output ready);
endinterface

// ----- rtl/bta_rsp_if.sv -----
// Response channel interface of the heap allocator.
interface bta_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [14:0] payload_addr;

   modport source (output valid, status, payload_addr, input ready);
   modport sink (input valid, status, payload_addr, output ready);
endinterface

// ----- rtl/boundary_tag_heap_allocator.sv -----
// Boundary-tag heap allocator: top level with heap memory and sequencer.
// The heap lives in one single-port-read, single-port-write memory of
// HEAP_WORDS 32-bit words with a registered read, and a sequencer works on
// one request word at a time. Init is shorter when the first chunk does not
// fit, and free takes longer the more free neighbors the block merges with.
// Allocate time grows with the number of block headers visited by the
// next-fit walk, and more when the heap has to grow, so its time follows the
// fragmentation of the heap. A zero request, the unused mode and any request
// before init go straight to the response. A finished response word waits in
// an output register while the sequencer returns to idle; the sequencer stalls
// in its last state only while the previous response word is still waiting.
// No clearing pass runs after reset.
module boundary_tag_heap_allocator #(
   parameter int HEAP_WORDS = 8192
) (
   input  logic        clock,
   input  logic        reset,
   bta_req_if.sink     req_chan,
   bta_rsp_if.source   rsp_chan,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);
   import bta_pkg::*;
   `include "boundary_tag_heap_allocator_defines.svh"

   localparam int WIW = $clog2(HEAP_WORDS);
   localparam int CAP = (HEAP_WORDS * 4 < 32768) ? HEAP_WORDS * 4 : 32768;

   logic [31:0] mem [HEAP_WORDS];
   logic [31:0] mem_q_ff;
   logic        rd_ok_ff;
   logic        mem_re, mem_we;
   logic [ADDR_W-1:0] mem_ra, mem_wa;
   logic [31:0] mem_wd, rdata;

   state_type state_ff, state_in;
   logic [1:0]  op_ff, op_in;
   logic [15:0] brk_ff, brk_in, first_ff, first_in, rover_ff, rover_in, chunk_ff;
   logic [16:0] asize_ff, asize_in, gbytes_ff, gbytes_in;
   logic [ADDR_W-1:0] bp_ff, bp_in, pv_ff, pv_in, end_ff, end_in;
   logic [31:0] size_ff, size_in, nsize_ff, nsize_in, tot_ff, tot_in, endv_ff, endv_in;
   logic        pa_ff, pa_in, na_ff, na_in, pbit_ff, pbit_in;
   logic        res_status_ff, res_status_in;
   logic [14:0] res_addr_ff, res_addr_in;
   logic        rsp_valid_ff, rsp_status_ff, rsp_load;
   logic [14:0] rsp_addr_ff;

   logic [31:0] rd_size, tmp_tot;
   logic [ADDR_W-1:0] nx, nb, tmp_a;
   logic [16:0] ce;

   function automatic logic in_range(input logic [ADDR_W-1:0] a);
      return a[ADDR_W-1:2] < (ADDR_W-2)'(HEAP_WORDS);
   endfunction

   always_ff @(posedge clock) begin
      if (mem_we && in_range(mem_wa)) begin
         mem[mem_wa[WIW+1:2]] <= mem_wd;
      end
      if (mem_re && in_range(mem_ra)) begin
         mem_q_ff <= mem[mem_ra[WIW+1:2]];
      end
      if (mem_re) begin
         rd_ok_ff <= in_range(mem_ra);
      end
   end

   assign rdata   = rd_ok_ff ? mem_q_ff : '0;
   assign rd_size = rdata & SIZE_MASK;
   assign nx      = bp_ff + ADDR_W'(size_ff);
   assign ce      = chunk_eff(chunk_ff);

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.payload_addr = rsp_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         brk_ff       <= '0;
         first_ff     <= '0;
         rover_ff     <= '0;
         chunk_ff     <= CHUNK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         brk_ff   <= brk_in;
         first_ff <= first_in;
         rover_ff <= rover_in;
         if (csr_we) begin
            chunk_ff <= csr_wdata;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      asize_ff      <= asize_in;
      gbytes_ff     <= gbytes_in;
      bp_ff         <= bp_in;
      pv_ff         <= pv_in;
      end_ff        <= end_in;
      size_ff       <= size_in;
      nsize_ff      <= nsize_in;
      tot_ff        <= tot_in;
      endv_ff       <= endv_in;
      pa_ff         <= pa_in;
      na_ff         <= na_in;
      pbit_ff       <= pbit_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_addr_ff   <= res_addr_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      brk_in        = brk_ff;
      first_in      = first_ff;
      rover_in      = rover_ff;
      asize_in      = asize_ff;
      gbytes_in     = gbytes_ff;
      bp_in         = bp_ff;
      pv_in         = pv_ff;
      end_in        = end_ff;
      size_in       = size_ff;
      nsize_in      = nsize_ff;
      tot_in        = tot_ff;
      endv_in       = endv_ff;
      pa_in         = pa_ff;
      na_in         = na_ff;
      pbit_in       = pbit_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      mem_re        = 1'b0;
      mem_ra        = bp_ff - ADDR_W'(4);
      mem_we        = 1'b0;
      mem_wa        = bp_ff - ADDR_W'(4);
      mem_wd        = '0;
      rsp_load      = 1'b0;
      nb            = bp_ff + ADDR_W'(rd_size);
      tmp_tot       = '0;
      tmp_a         = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               op_in         = req_chan.mode;
               asize_in      = alloc_size(req_chan.req_bytes);
               res_status_in = 1'b1;
               res_addr_in   = '0;
               state_in      = S_DONE;
               case (req_chan.mode)
                  MODE_INIT: begin
                     state_in = S_INIT0;
                  end
                  MODE_ALLOC: begin
                     if (brk_ff != '0 && req_chan.req_bytes != '0) begin
                        bp_in    = ADDR_W'(rover_ff);
                        mem_re   = 1'b1;
                        mem_ra   = ADDR_W'(rover_ff) - ADDR_W'(4);
                        state_in = S_SR1;
                     end
                  end
                  MODE_FREE: begin
                     if (brk_ff != '0) begin
                        bp_in    = ADDR_W'(req_chan.block_addr);
                        mem_re   = 1'b1;
                        mem_ra   = ADDR_W'(req_chan.block_addr) - ADDR_W'(4);
                        state_in = S_FR_H;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_INIT0: begin
            mem_we   = 1'b1;
            mem_wa   = ADDR_W'(0);
            mem_wd   = '0;
            state_in = S_INIT1;
         end
         S_INIT1: begin
            mem_we   = 1'b1;
            mem_wa   = ADDR_W'(4);
            mem_wd   = HDR_PROLOGUE;
            state_in = S_INIT2;
         end
         S_INIT2: begin
            mem_we   = 1'b1;
            mem_wa   = ADDR_W'(8);
            mem_wd   = HDR_PROLOGUE;
            state_in = S_INIT3;
         end
         S_INIT3: begin
            mem_we    = 1'b1;
            mem_wa    = ADDR_W'(12);
            mem_wd    = HDR_EPI_INIT;
            brk_in    = 16'd16;
            first_in  = 16'd8;
            rover_in  = 16'd8;
            gbytes_in = ce;
            state_in  = S_GROW;
         end
         S_GROW: begin
            if (18'(brk_ff) + 18'(gbytes_ff) > 18'(CAP)) begin
               res_status_in = 1'b1;
               state_in      = S_DONE;
            end else begin
               bp_in    = ADDR_W'(brk_ff);
               brk_in   = brk_ff + gbytes_ff[15:0];
               mem_re   = 1'b1;
               mem_ra   = ADDR_W'(brk_ff) - ADDR_W'(4);
               state_in = S_GROW_H;
            end
         end
         S_GROW_H: begin
            pbit_in  = rdata[1];
            mem_we   = 1'b1;
            mem_wd   = 32'(gbytes_ff) | {30'b0, rdata[1], 1'b0};
            state_in = S_GROW_W1;
         end
         S_GROW_W1: begin
            mem_we   = 1'b1;
            mem_wa   = bp_ff + ADDR_W'(gbytes_ff) - ADDR_W'(8);
            mem_wd   = 32'(gbytes_ff) | {30'b0, pbit_ff, 1'b0};
            state_in = S_GROW_W2;
         end
         S_GROW_W2: begin
            mem_we   = 1'b1;
            mem_wa   = bp_ff + ADDR_W'(gbytes_ff) - ADDR_W'(4);
            mem_wd   = HDR_EPILOGUE;
            state_in = S_MRG;
         end
         S_MRG: begin
            mem_re   = 1'b1;
            state_in = S_MRG_H;
         end
         S_MRG_H: begin
            size_in  = rd_size;
            pa_in    = rdata[1];
            mem_re   = 1'b1;
            mem_ra   = bp_ff + ADDR_W'(rd_size) - ADDR_W'(4);
            state_in = S_MRG_N;
         end
         S_MRG_N: begin
            nsize_in = rd_size;
            na_in    = rdata[0];
            if (pa_ff && rdata[0]) begin
               mem_we   = 1'b1;
               mem_wd   = size_ff | 32'd2;
               state_in = S_MRET;
            end else if (pa_ff) begin
               if (ADDR_W'(rover_ff) == nx) begin
                  rover_in = bp_ff[15:0];
               end
               tmp_tot  = size_ff + rd_size;
               mem_we   = 1'b1;
               mem_wd   = tmp_tot | 32'd2;
               endv_in  = tmp_tot | 32'd2;
               end_in   = bp_ff + ADDR_W'(tmp_tot) - ADDR_W'(8);
               state_in = S_MW2;
            end else begin
               mem_re   = 1'b1;
               mem_ra   = bp_ff - ADDR_W'(8);
               state_in = S_MRG_F;
            end
         end
         S_MRG_F: begin
            tmp_a    = bp_ff - ADDR_W'(rd_size);
            pv_in    = tmp_a;
            mem_re   = 1'b1;
            mem_ra   = tmp_a - ADDR_W'(4);
            state_in = S_MRG_P;
         end
         S_MRG_P: begin
            if (na_ff) begin
               if (ADDR_W'(rover_ff) == bp_ff) begin
                  rover_in = pv_ff[15:0];
               end
               tmp_tot = size_ff + rd_size;
               end_in  = nx - ADDR_W'(8);
            end else begin
               if (ADDR_W'(rover_ff) == bp_ff || ADDR_W'(rover_ff) == nx) begin
                  rover_in = pv_ff[15:0];
               end
               tmp_tot = size_ff + rd_size + nsize_ff;
               end_in  = nx + ADDR_W'(nsize_ff) - ADDR_W'(8);
            end
            mem_we   = 1'b1;
            mem_wa   = pv_ff - ADDR_W'(4);
            mem_wd   = tmp_tot | {30'b0, rdata[1], 1'b0};
            endv_in  = tmp_tot | {30'b0, rdata[1], 1'b0};
            bp_in    = pv_ff;
            state_in = S_MW2;
         end
         S_MW2: begin
            mem_we   = 1'b1;
            mem_wa   = end_ff;
            mem_wd   = endv_ff;
            state_in = S_MRET;
         end
         S_MRET: begin
            if (op_ff == MODE_ALLOC) begin
               mem_re   = 1'b1;
               state_in = S_PL_H;
            end else begin
               res_status_in = 1'b0;
               state_in      = S_DONE;
            end
         end
         S_SR1: begin
            if (rd_size == '0) begin
               bp_in = ADDR_W'(first_ff);
               if (first_ff < rover_ff) begin
                  mem_re   = 1'b1;
                  mem_ra   = ADDR_W'(first_ff) - ADDR_W'(4);
                  state_in = S_SR2;
               end else begin
                  gbytes_in = (asize_ff > ce) ? asize_ff : ce;
                  state_in  = S_GROW;
               end
            end else if (!rdata[0] && 32'(asize_ff) <= rd_size) begin
               rover_in = bp_ff[15:0];
               state_in = S_PL;
            end else begin
               bp_in  = nb;
               mem_re = 1'b1;
               mem_ra = nb - ADDR_W'(4);
            end
         end
         S_SR2: begin
            if (rd_size == '0) begin
               gbytes_in = (asize_ff > ce) ? asize_ff : ce;
               state_in  = S_GROW;
            end else if (!rdata[0] && 32'(asize_ff) <= rd_size) begin
               rover_in = bp_ff[15:0];
               state_in = S_PL;
            end else if (nb < ADDR_W'(rover_ff)) begin
               bp_in  = nb;
               mem_re = 1'b1;
               mem_ra = nb - ADDR_W'(4);
            end else begin
               gbytes_in = (asize_ff > ce) ? asize_ff : ce;
               state_in  = S_GROW;
            end
         end
         S_PL: begin
            mem_re   = 1'b1;
            state_in = S_PL_H;
         end
         S_PL_H: begin
            size_in = rd_size;
            mem_we  = 1'b1;
            if (rd_size >= 32'(asize_ff) && rd_size - 32'(asize_ff) >= 32'd8) begin
               tot_in   = rd_size - 32'(asize_ff);
               mem_wd   = 32'(asize_ff) | {30'b0, rdata[1], 1'b1};
               state_in = S_PL_S1;
            end else begin
               mem_wd   = rd_size | {30'b0, rdata[1], 1'b1};
               state_in = S_PL_R;
            end
         end
         S_PL_S1: begin
            mem_we   = 1'b1;
            mem_wa   = bp_ff + ADDR_W'(asize_ff) - ADDR_W'(4);
            mem_wd   = tot_ff | 32'd2;
            state_in = S_PL_S2;
         end
         S_PL_S2: begin
            mem_we        = 1'b1;
            mem_wa        = nx - ADDR_W'(8);
            mem_wd        = tot_ff | 32'd2;
            res_status_in = 1'b0;
            res_addr_in   = bp_ff[14:0];
            state_in      = S_DONE;
         end
         S_PL_R: begin
            mem_re   = 1'b1;
            mem_ra   = nx - ADDR_W'(4);
            state_in = S_PL_N;
         end
         S_PL_N: begin
            mem_we        = 1'b1;
            mem_wa        = nx - ADDR_W'(4);
            mem_wd        = rd_size | {30'b0, 1'b1, rdata[0]};
            res_status_in = 1'b0;
            res_addr_in   = bp_ff[14:0];
            state_in      = S_DONE;
         end
         S_FR_H: begin
            size_in  = rd_size;
            endv_in  = rd_size | {30'b0, rdata[1], 1'b0};
            mem_we   = 1'b1;
            mem_wd   = rd_size | {30'b0, rdata[1], 1'b0};
            state_in = S_FR_W;
         end
         S_FR_W: begin
            mem_we   = 1'b1;
            mem_wa   = nx - ADDR_W'(8);
            mem_wd   = endv_ff;
            state_in = S_FR_R;
         end
         S_FR_R: begin
            mem_re   = 1'b1;
            mem_ra   = nx - ADDR_W'(4);
            state_in = S_FR_N;
         end
         S_FR_N: begin
            mem_we   = 1'b1;
            mem_wa   = nx - ADDR_W'(4);
            mem_wd   = rd_size | {31'b0, rdata[0]};
            state_in = S_MRG;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `BTA_ASSERT_NOW(a_no_rw_overlap, mem_re, !mem_we, "heap memory read and written in one cycle")
   `BTA_ASSERT_NOW(a_break_aligned, 1'b1, brk_ff[2:0] == 3'd0 && 32'(brk_ff) <= 32'(CAP),
      "heap break misaligned or beyond capacity")
   `BTA_ASSERT_NEXT(a_rsp_loaded, rsp_load, rsp_valid_ff && state_ff == S_IDLE,
      "finished response word not presented")
   `BTA_ASSERT_NEXT(a_rover_idle, state_ff == S_IDLE && !req_chan.valid, $stable(rover_ff),
      "rover moved while idle")

endmodule

// ----- bench/boundary_tag_heap_allocator_tb.sv -----
// Testbench of the boundary-tag heap allocator with a self-checking heap predictor.
`timescale 1ns / 100ps

module boundary_tag_heap_allocator_tb;
   import bta_pkg::*;

   localparam int  MEM_WORDS   = 8192;
   localparam int  CAP         = 32768;
   localparam longint LIMIT    = 20000000;

   typedef struct packed {
      logic        status;
      logic [14:0] payload_addr;
   } alloc_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = 16'd0;

   bta_req_if req_bus ();
   bta_rsp_if rsp_bus ();

   boundary_tag_heap_allocator #(.HEAP_WORDS(MEM_WORDS)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // Predicted heap state.
   bit [31:0]   heap_mem [0:MEM_WORDS-1];
   longint      heap_brk;
   longint      heap_first;
   longint      heap_rover;
   bit [15:0]   chunk_reg;

   alloc_result_type expected_results[$];
   int          live_blocks[$];
   int          fail_count = 0;
   longint      cycle_count = 0;
   int          burst_left;
   int          n_alloc_ok, n_alloc_fail, n_free, n_init;

   function automatic bit [31:0] heap_rd(longint a);
      if (a < 0 || (a >>> 2) >= MEM_WORDS) return 32'd0;
      return heap_mem[a >>> 2];
   endfunction

   function automatic void heap_wr(longint a, bit [31:0] v);
      if (a >= 0 && (a >>> 2) < MEM_WORDS) heap_mem[a >>> 2] = v;
   endfunction

   function automatic void move_rover(longint p);
      heap_rover = p & 64'hFFFF;
   endfunction

   function automatic longint coalesce(longint bp);
      bit [31:0] h, nh, ph, total, pbit, sz, nsz;
      longint    nx, pv, tail;
      bit        pa, na;
      h = heap_rd(bp - 4);
      sz = h & SIZE_MASK;
      nx = bp + sz;
      nh = heap_rd(nx - 4);
      nsz = nh & SIZE_MASK;
      pa = h[1];
      na = nh[0];
      if (pa && na) begin
         heap_wr(bp - 4, sz | 32'd2);
         return bp;
      end
      if (pa) begin
         if (nx == heap_rover) move_rover(bp);
         total = sz + nsz;
         heap_wr(bp - 4, total | 32'd2);
         heap_wr(bp + total - 8, total | 32'd2);
         return bp;
      end
      pv = bp - longint'(heap_rd(bp - 8) & SIZE_MASK);
      ph = heap_rd(pv - 4);
      pbit = ph & 32'd2;
      if (na) begin
         if (heap_rover == bp) move_rover(pv);
         total = sz + (ph & SIZE_MASK);
         tail = bp + sz - 8;
      end else begin
         if (heap_rover == bp || heap_rover == nx) move_rover(pv);
         total = sz + (ph & SIZE_MASK) + nsz;
         tail = nx + nsz - 8;
      end
      heap_wr(pv - 4, total | pbit);
      heap_wr(tail, total | pbit);
      return pv;
   endfunction

   function automatic bit grow_heap(bit [31:0] bytes, output longint bp);
      longint    base;
      bit [31:0] pbit;
      base = heap_brk;
      bp = 0;
      if (heap_brk + bytes > CAP) return 1'b0;
      heap_brk = heap_brk + bytes;
      pbit = heap_rd(base - 4) & 32'd2;
      heap_wr(base - 4, bytes | pbit);
      heap_wr(base + bytes - 8, bytes | pbit);
      heap_wr(base + bytes - 4, 32'd1);
      bp = coalesce(base);
      return 1'b1;
   endfunction

   function automatic bit [31:0] chunk_bytes();
      bit [31:0] c;
      c = (32'(chunk_reg) + 32'd7) & SIZE_MASK;
      return (c == 0) ? 32'd8 : c;
   endfunction

   function automatic bit block_fits(longint bp, bit [31:0] asize);
      bit [31:0] h;
      h = heap_rd(bp - 4);
      return !h[0] && asize <= (h & SIZE_MASK);
   endfunction

   function automatic bit next_fit(bit [31:0] asize, output longint bp);
      bit [31:0] s;
      bp = heap_rover;
      s = heap_rd(bp - 4) & SIZE_MASK;
      while (s > 0) begin
         if (block_fits(bp, asize)) begin
            move_rover(bp);
            return 1'b1;
         end
         bp = bp + s;
         s = heap_rd(bp - 4) & SIZE_MASK;
      end
      bp = heap_first;
      while (bp < heap_rover) begin
         s = heap_rd(bp - 4) & SIZE_MASK;
         if (s == 0) break;
         if (block_fits(bp, asize)) begin
            move_rover(bp);
            return 1'b1;
         end
         bp = bp + s;
      end
      return 1'b0;
   endfunction

   function automatic void place_block(longint bp, bit [31:0] asize);
      bit [31:0] h, sz, pbit, nh;
      h = heap_rd(bp - 4);
      sz = h & SIZE_MASK;
      pbit = h & 32'd2;
      if (sz >= asize && sz - asize >= 8) begin
         heap_wr(bp - 4, asize | pbit | 32'd1);
         heap_wr(bp + asize - 4, (sz - asize) | 32'd2);
         heap_wr(bp + sz - 8, (sz - asize) | 32'd2);
      end else begin
         heap_wr(bp - 4, sz | pbit | 32'd1);
         nh = heap_rd(bp + sz - 4);
         heap_wr(bp + sz - 4, (nh & SIZE_MASK) | (nh & 32'd1) | 32'd2);
      end
   endfunction

   function automatic alloc_result_type predict_word(logic [1:0] mode, logic [15:0] nbytes,
                                                     logic [14:0] baddr);
      alloc_result_type r;
      longint        bp, p;
      bit [31:0]     asize, c, h, sz, v, nh;
      bit            ok;
      r.status = 1'b1;
      r.payload_addr = 15'd0;
      if (mode == MODE_INIT) begin
         heap_brk = 16;
         heap_wr(0, 32'd0);
         heap_wr(4, HDR_PROLOGUE);
         heap_wr(8, HDR_PROLOGUE);
         heap_wr(12, HDR_EPI_INIT);
         heap_first = 8;
         heap_rover = 8;
         r.status = !grow_heap(chunk_bytes(), bp);
      end else if (mode == MODE_ALLOC) begin
         if (heap_brk != 0 && nbytes != 0) begin
            asize = (nbytes <= 4) ? 32'd8 : ((32'(nbytes) + 32'd11) & SIZE_MASK);
            ok = next_fit(asize, bp);
            if (!ok) begin
               c = chunk_bytes();
               ok = grow_heap((asize > c) ? asize : c, bp);
            end
            if (ok) begin
               place_block(bp, asize);
               r.status = 1'b0;
               r.payload_addr = bp[14:0];
            end
         end
      end else if (mode == MODE_FREE) begin
         if (heap_brk != 0) begin
            p = longint'(baddr);
            h = heap_rd(p - 4);
            sz = h & SIZE_MASK;
            v = sz | (h & 32'd2);
            heap_wr(p - 4, v);
            heap_wr(p + sz - 8, v);
            nh = heap_rd(p + sz - 4);
            heap_wr(p + sz - 4, (nh & SIZE_MASK) | (nh & 32'd1));
            bp = coalesce(p);
            r.status = 1'b0;
         end
      end
      return r;
   endfunction

   // Sends one word; valid stays high on return unless a random gap follows, so a following word can go back to back.
   task automatic send_word(logic [1:0] mode, logic [15:0] nbytes, logic [14:0] baddr);
      alloc_result_type r;
      bit            taken;
      int            gap;
      req_bus.valid <= 1'b1;
      req_bus.mode <= mode;
      req_bus.req_bytes <= nbytes;
      req_bus.block_addr <= baddr;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_bus.ready;
         @(posedge clock);
      end
      r = predict_word(mode, nbytes, baddr);
      expected_results.push_back(r);
      if (mode == MODE_INIT) begin
         live_blocks.delete();
         n_init++;
      end else if (mode == MODE_ALLOC) begin
         if (!r.status) begin
            live_blocks.push_back(int'(r.payload_addr));
            n_alloc_ok++;
         end else n_alloc_fail++;
      end else if (mode == MODE_FREE) n_free++;
      if (burst_left > 0) burst_left--;
      else begin
         burst_left = $urandom_range(0, 15);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_chunk(logic [15:0] value);
      drain_results();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      chunk_reg = value;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic free_live(int idx);
      int a;
      a = live_blocks[idx];
      live_blocks.delete(idx);
      send_word(MODE_FREE, 16'd0, a[14:0]);
   endtask

   task automatic test_before_init();
      send_word(MODE_ALLOC, 16'd8, 15'd0);
      send_word(MODE_FREE, 16'd0, 15'h7FFF);
      send_word(MODE_UNUSED, 16'hFFFF, 15'h7FFF);
      send_word(MODE_ALLOC, 16'hFFFF, 15'd0);
   endtask

   task automatic test_directed_extremes();
      write_chunk(16'd32768);
      send_word(MODE_INIT, 16'd0, 15'd0);
      send_word(MODE_ALLOC, 16'd1, 15'd0);
      write_chunk(16'd0);
      send_word(MODE_ALLOC, 16'd4, 15'd0);
      send_word(MODE_ALLOC, 16'd5, 15'd0);
      write_chunk(16'd4096);
      send_word(MODE_INIT, 16'd0, 15'd0);
      send_word(MODE_ALLOC, 16'd0, 15'd0);
      send_word(MODE_ALLOC, 16'd20000, 15'd0);
      send_word(MODE_ALLOC, 16'd100, 15'd0);
      send_word(MODE_ALLOC, 16'd32768, 15'd0);
      send_word(MODE_ALLOC, 16'd12, 15'd0);
      send_word(MODE_UNUSED, 16'd0, 15'd0);
      free_live(1);
      free_live(0);
      send_word(MODE_ALLOC, 16'd9000, 15'd0);
      while (live_blocks.size() != 0) free_live(live_blocks.size() - 1);
      write_chunk(16'd65535);
      send_word(MODE_INIT, 16'd0, 15'd0);
   endtask

   task automatic test_random_traffic(logic [15:0] chunk, int count);
      int       pick;
      logic [15:0] nb;
      write_chunk(chunk);
      send_word(MODE_INIT, 16'd0, 15'd0);
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 2) send_word(MODE_INIT, 16'($urandom), 15'($urandom));
         else if (pick < 4) send_word(MODE_UNUSED, 16'($urandom), 15'($urandom));
         else if (pick < 42 && live_blocks.size() != 0)
            free_live($urandom_range(0, live_blocks.size() - 1));
         else begin
            pick = $urandom_range(0, 99);
            if (pick < 2) nb = 16'd0;
            else if (pick < 60) nb = 16'($urandom_range(1, 64));
            else if (pick < 90) nb = 16'($urandom_range(65, 1024));
            else if (pick < 98) nb = 16'($urandom_range(1025, 8192));
            else nb = 16'($urandom_range(8193, 32768));
            send_word(MODE_ALLOC, nb, 15'($urandom));
         end
         if (i == count / 2) drain_results();
      end
   endtask

   // Response ready steps in turn through four patterns: always high, random, periodic and random again.
   always @(posedge clock) begin
      case ((cycle_count / 300) % 4)
         0: begin
            rsp_bus.ready <= 1'b1;
         end
         1: begin
            rsp_bus.ready <= ($urandom_range(0, 9) < 7);
         end
         2: begin
            rsp_bus.ready <= (cycle_count % 7) < 2;
         end
         default: begin
            rsp_bus.ready <= ($urandom_range(0, 1) == 1);
         end
      endcase
   end

   always @(negedge clock) begin
      alloc_result_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected response word: status %0d addr %0d",
                   rsp_bus.status, rsp_bus.payload_addr);
            fail_count++;
         end else begin
            e = expected_results.pop_front();
            if (rsp_bus.status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_bus.status);
               fail_count++;
            end
            if (rsp_bus.payload_addr !== e.payload_addr) begin
               $error("payload_addr: expected %0d, got %0d", e.payload_addr,
                      rsp_bus.payload_addr);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.mode = MODE_INIT;
      req_bus.req_bytes = 16'd0;
      req_bus.block_addr = 15'd0;
      burst_left = 0;
      heap_brk = 0;
      heap_first = 0;
      heap_rover = 0;
      chunk_reg = CHUNK_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_before_init();
      test_directed_extremes();
      test_random_traffic(16'd4096, 90);
      test_random_traffic(16'd8, 90);
      test_random_traffic(16'd13, 90);
      test_random_traffic(16'd32760, 90);
      test_random_traffic(16'($urandom_range(1, 2048) * 8), 90);
      drain_results();
      $display("Covered %0d inits, %0d frees, %0d good and %0d failed allocations.",
               n_init, n_free, n_alloc_ok, n_alloc_fail);
      $display("Chunk settings ranged from zero to the largest register value.");
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/bta_pkg.sv
rtl/bta_req_if.sv
rtl/bta_rsp_if.sv
rtl/boundary_tag_heap_allocator.sv
bench/boundary_tag_heap_allocator_tb.sv
